>>> rtl/assert_macros.svh
// Assertion helpers, sampled on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define OCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OCG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define OCG_ASSERT(lbl, prop, msg)
`define OCG_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/ocg_pkg.sv
package ocg_pkg;

  localparam int unsigned DIV_NW     = 25;
  localparam int unsigned DIV_DW     = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NEW   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_BAD_READ  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PADDING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_CODE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_CODE = 3'd7;

  localparam logic signed [23:0] POS24 = 24'sh7FFFFF;
  localparam logic signed [23:0] NEG24 = 24'sh800000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] point_x_mm;
    logic signed [23:0] point_y_mm;
    logic signed [23:0] point_z_mm;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
  } in_t;

  typedef struct packed {
    logic signed [7:0]  cell_value;
    logic [8:0]         grid_cols;
    logic [8:0]         grid_rows;
    logic signed [23:0] origin_x_mm;
    logic signed [23:0] origin_y_mm;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } pt_t;

endpackage

>>> rtl/ocg_div.sv
module ocg_div import ocg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   sh, diff;
  logic              ge;

  // restoring, one quotient bit a cycle
  always_comb begin
    sh   = {rem_q, quo_q[DIV_NW-1]};
    ge   = sh >= {1'b0, den_q};
    diff = sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DIV_NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/ocg_isqrt.sv
module ocg_isqrt import ocg_pkg::*; #(
  parameter int unsigned OW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*OW-1:0] val_i,
  output logic            done_o,
  output logic [OW-1:0]   root_o
);
  logic [OW-1:0]   m_q, r_q, t;
  logic [2*OW-1:0] val_q, sq;
  logic            done_q;

  // one root bit a cycle, MSB first
  always_comb begin
    t  = r_q | m_q;
    sq = (2*OW)'(t) * (2*OW)'(t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        m_q <= {1'b1, {(OW-1){1'b0}}};
      end else if (m_q != '0) begin
        m_q <= m_q >> 1;
        if (m_q[0]) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      val_q <= val_i;
    end else if (m_q != '0 && sq <= val_q) begin
      r_q <= t;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q;

endmodule

>>> rtl/point_cloud_occupancy_grid_builder_top.sv
// Occupancy grid builder.
// Command channel: start with in_i is taken when busy is low; every command gives
// exactly one result beat on res_o, marked by done_o for one cycle. The receiver
// cannot stall, so results are never held.
// mode load: result the cycle after start, busy stays low; one point per cycle.
// mode new map: result the cycle after start.
// mode read: the map memory read is registered, then S_RD registers the cell.
// mode build: three serial divisions (grid width, height, disc radius), then a
// pass clearing the seed and map memories, then per stored point two divisions,
// then a registered seed read per grid cell, and per seeded cell and disc row a
// square root, the set-up states S_DY and S_XR, and one write per cell stamped.
// A build without points answers the cycle after start. A grid of zero or
// oversize answers after the three divisions, without touching the memories.
// Configuration writes land at once; the user must make them only while the
// block is idle, which the block itself does not enforce.
// Reset restores register defaults, empties the point box and store, and marks no
// grid valid; the memories need no clearing at reset.
`include "assert_macros.svh"

module point_cloud_occupancy_grid_builder_top import ocg_pkg::*; #(
  parameter int unsigned MAX_BAND_POINTS = 4096,
  parameter int unsigned MAX_GRID_COLS   = 256,
  parameter int unsigned MAX_GRID_ROWS   = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_i,
  output logic                  done_o,
  output out_t                  res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);
  localparam int unsigned BAW       = $clog2(MAX_BAND_POINTS);
  localparam int unsigned BCW       = $clog2(MAX_BAND_POINTS + 1);
  localparam int unsigned COL_W     = $clog2(MAX_GRID_COLS);
  localparam int unsigned ROW_W     = $clog2(MAX_GRID_ROWS);
  localparam int unsigned MAP_DEPTH = MAX_GRID_COLS * MAX_GRID_ROWS;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam int unsigned GMAX      = (MAX_GRID_COLS > MAX_GRID_ROWS) ?
                                      MAX_GRID_COLS : MAX_GRID_ROWS;
  localparam int unsigned D_CAP     = 2 * GMAX;
  localparam int unsigned DW        = $clog2(D_CAP + 1);
  localparam int unsigned EW        = DW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DW, S_DH, S_DD, S_CLR, S_PRD, S_PX, S_PY,
    S_SRD, S_SCHK, S_DY, S_SQ, S_XR, S_FILL, S_FIN
  } state_e;

  // configuration
  logic [13:0]        cell_size_q;
  logic [16:0]        padding_q, radius_q;
  logic signed [23:0] ground_q;
  logic signed [17:0] band_lo_q, band_hi_q;
  logic signed [7:0]  occ_code_q, free_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= 14'd100;
      padding_q   <= 17'd1000;
      ground_q    <= '0;
      band_lo_q   <= 18'sd150;
      band_hi_q   <= 18'sd1800;
      radius_q    <= 17'd150;
      occ_code_q  <= 8'sd100;
      free_code_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELL_SIZE: cell_size_q <= cfg_wdata_i[13:0];
        REG_PADDING:   padding_q   <= cfg_wdata_i[16:0];
        REG_GROUND:    ground_q    <= cfg_wdata_i;
        REG_BAND_LOW:  band_lo_q   <= cfg_wdata_i[17:0];
        REG_BAND_HIGH: band_hi_q   <= cfg_wdata_i[17:0];
        REG_RADIUS:    radius_q    <= cfg_wdata_i[16:0];
        REG_OCC_CODE:  occ_code_q  <= cfg_wdata_i[7:0];
        REG_FREE_CODE: free_code_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // state
  state_e             state_q;
  logic               done_q, read_ok_q, has_pts_q, valid_q;
  logic signed [7:0]  cell_q;
  logic [2:0]         status_q;
  logic signed [23:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic [BCW-1:0]     band_cnt_q, i_q;
  logic [8:0]         built_cols_q, built_rows_q;
  logic signed [23:0] org_x_q, org_y_q;
  logic signed [24:0] ox_q, oy_q;
  logic [DIV_NW-1:0]  w_q, h_q, gx_q;
  logic [DW-1:0]      d_q, hw_q;
  logic [2*DW-1:0]    d2_q;
  logic [2*ROW_W-1:0] dy2_q;
  logic [MAP_AW-1:0]  clr_q;
  logic [COL_W-1:0]   cx_q, x_q, xhi_q;
  logic [ROW_W-1:0]   cy_q, y_q, yhi_q;
  logic               div_run_q, sq_run_q;

  // memories
  pt_t  band_mem [MAX_BAND_POINTS];
  logic seed_mem [MAP_DEPTH];
  logic occ_mem  [MAP_DEPTH];
  pt_t  band_rd_q;
  logic seed_rd_q, occ_rd_q;

  logic              band_we, seed_we, seed_wd, occ_we, occ_wd;
  logic [BAW-1:0]    band_wa;
  logic [MAP_AW-1:0] seed_wa, seed_ra, occ_wa, occ_ra;

  // combinational helpers
  logic               accept, in_band, band_full, bad_read;
  logic [13:0]        res_eff;
  logic signed [24:0] z_s, band_lo_s, band_hi_s, pad_s, ox_s, oy_s;
  logic signed [24:0] ext_x, ext_y, bx_s, by_s;
  logic [DIV_NW-1:0]  wnum_x, wnum_y, dnum, div_num, div_quo;
  logic               div_start, div_done, sq_start, sq_done;
  logic [DW-1:0]      sq_root, d_cap;
  logic [EW-1:0]      cx_e, cy_e, d_e, hw_e, ysum, xsum, ydif, xdif;
  logic [ROW_W-1:0]   hm1, ylo, yhi, dy;
  logic [COL_W-1:0]   wm1, xlo, xhi;
  logic [2*ROW_W-1:0] dy2;
  logic [2*DW-1:0]    sq_val;
  logic               last_col, last_row, seed_hit;
  logic [COL_W-1:0]   nx_cx;
  logic [ROW_W-1:0]   nx_cy;

  always_comb begin
    accept    = start && !busy;
    res_eff   = (cell_size_q == '0) ? 14'd1 : cell_size_q;
    z_s       = 25'(in_i.point_z_mm);
    band_lo_s = 25'(ground_q) + 25'(band_lo_q);
    band_hi_s = 25'(ground_q) + 25'(band_hi_q);
    in_band   = (z_s >= band_lo_s) && (z_s <= band_hi_s);
    band_full = band_cnt_q == BCW'(MAX_BAND_POINTS);
    bad_read  = !valid_q || ({1'b0, in_i.cell_col} >= built_cols_q) ||
                ({1'b0, in_i.cell_row} >= built_rows_q);
    pad_s     = $signed(25'(padding_q));
    ox_s      = 25'(min_x_q) - pad_s;
    oy_s      = 25'(min_y_q) - pad_s;
    ext_x     = 25'(max_x_q) - 25'(min_x_q);
    ext_y     = 25'(max_y_q) - 25'(min_y_q);
    wnum_x    = $unsigned(ext_x) + 25'({padding_q, 1'b0}) + 25'(res_eff) - 25'd1;
    wnum_y    = $unsigned(ext_y) + 25'({padding_q, 1'b0}) + 25'(res_eff) - 25'd1;
    dnum      = 25'(radius_q) + 25'(res_eff) - 25'd1;
    bx_s      = 25'(band_rd_q.x) - ox_q;
    by_s      = 25'(band_rd_q.y) - oy_q;

    case (state_q)
      S_DW:    div_num = wnum_x;
      S_DH:    div_num = wnum_y;
      S_DD:    div_num = dnum;
      S_PX:    div_num = $unsigned(bx_s);
      S_PY:    div_num = $unsigned(by_s);
      default: div_num = '0;
    endcase
    div_start = !div_run_q && (state_q == S_DW || state_q == S_DH || state_q == S_DD ||
                               state_q == S_PX || state_q == S_PY);
    d_cap     = (div_quo > DIV_NW'(D_CAP)) ? DW'(D_CAP) : div_quo[DW-1:0];

    // disc geometry
    wm1  = w_q[COL_W-1:0] - 1'b1;
    hm1  = h_q[ROW_W-1:0] - 1'b1;
    cx_e = EW'(cx_q);
    cy_e = EW'(cy_q);
    d_e  = EW'(d_q);
    hw_e = EW'(hw_q);
    ydif = cy_e - d_e;
    ysum = cy_e + d_e;
    xdif = cx_e - hw_e;
    xsum = cx_e + hw_e;
    ylo  = (cy_e > d_e) ? ydif[ROW_W-1:0] : '0;
    yhi  = (ysum > EW'(hm1)) ? hm1 : ysum[ROW_W-1:0];
    xlo  = (cx_e > hw_e) ? xdif[COL_W-1:0] : '0;
    xhi  = (xsum > EW'(wm1)) ? wm1 : xsum[COL_W-1:0];
    dy   = (y_q >= cy_q) ? (y_q - cy_q) : (cy_q - y_q);
    dy2  = (2*ROW_W)'(dy) * (2*ROW_W)'(dy);
    sq_val   = d2_q - (2*DW)'(dy2_q);
    sq_start = (state_q == S_SQ) && !sq_run_q;

    last_col = cx_q == wm1;
    last_row = cy_q == hm1;
    nx_cx    = last_col ? '0 : cx_q + 1'b1;
    nx_cy    = last_col ? cy_q + 1'b1 : cy_q;
    seed_hit = (gx_q < w_q) && (div_quo < h_q);

    // memory ports
    band_we = accept && in_i.mode == MODE_LOAD && in_band && !band_full;
    band_wa = band_cnt_q[BAW-1:0];
    seed_ra = MAP_AW'(MAP_AW'(cy_q) * MAP_AW'(MAX_GRID_COLS) + MAP_AW'(cx_q));
    occ_ra  = MAP_AW'(MAP_AW'(in_i.cell_row) * MAP_AW'(MAX_GRID_COLS) +
                      MAP_AW'(in_i.cell_col));
    seed_we = 1'b0;
    seed_wd = 1'b0;
    seed_wa = clr_q;
    occ_we  = 1'b0;
    occ_wd  = 1'b0;
    occ_wa  = clr_q;
    case (state_q)
      S_CLR: begin
        seed_we = 1'b1;
        occ_we  = 1'b1;
      end
      S_PY: begin
        seed_we = div_done && seed_hit;
        seed_wd = 1'b1;
        seed_wa = MAP_AW'(MAP_AW'(div_quo[ROW_W-1:0]) * MAP_AW'(MAX_GRID_COLS) +
                          MAP_AW'(gx_q[COL_W-1:0]));
      end
      S_FILL: begin
        occ_we = 1'b1;
        occ_wd = 1'b1;
        occ_wa = MAP_AW'(MAP_AW'(y_q) * MAP_AW'(MAX_GRID_COLS) + MAP_AW'(x_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (band_we) band_mem[band_wa] <= '{x: in_i.point_x_mm, y: in_i.point_y_mm};
    band_rd_q <= band_mem[i_q[BAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (seed_we) seed_mem[seed_wa] <= seed_wd;
    seed_rd_q <= seed_mem[seed_ra];
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    occ_rd_q <= occ_mem[occ_ra];
  end

  ocg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (res_eff),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  ocg_isqrt #(.OW(DW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      read_ok_q    <= 1'b0;
      has_pts_q    <= 1'b0;
      valid_q      <= 1'b0;
      cell_q       <= '0;
      status_q     <= ST_OK;
      min_x_q      <= POS24;
      min_y_q      <= POS24;
      max_x_q      <= NEG24;
      max_y_q      <= NEG24;
      band_cnt_q   <= '0;
      i_q          <= '0;
      built_cols_q <= '0;
      built_rows_q <= '0;
      org_x_q      <= '0;
      org_y_q      <= '0;
      ox_q         <= '0;
      oy_q         <= '0;
      w_q          <= '0;
      h_q          <= '0;
      gx_q         <= '0;
      d_q          <= '0;
      hw_q         <= '0;
      d2_q         <= '0;
      dy2_q        <= '0;
      clr_q        <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      x_q          <= '0;
      xhi_q        <= '0;
      y_q          <= '0;
      yhi_q        <= '0;
      div_run_q    <= 1'b0;
      sq_run_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (div_start) div_run_q <= 1'b1;
      if (div_done)  div_run_q <= 1'b0;
      if (sq_start)  sq_run_q  <= 1'b1;
      if (sq_done)   sq_run_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cell_q   <= '0;
            status_q <= ST_OK;
            case (in_i.mode)
              MODE_LOAD: begin
                done_q    <= 1'b1;
                has_pts_q <= 1'b1;
                if (in_i.point_x_mm < min_x_q) min_x_q <= in_i.point_x_mm;
                if (in_i.point_y_mm < min_y_q) min_y_q <= in_i.point_y_mm;
                if (in_i.point_x_mm > max_x_q) max_x_q <= in_i.point_x_mm;
                if (in_i.point_y_mm > max_y_q) max_y_q <= in_i.point_y_mm;
                if (in_band) begin
                  if (band_full) status_q <= ST_FULL;
                  else band_cnt_q <= band_cnt_q + 1'b1;
                end
              end
              MODE_BUILD: begin
                if (!has_pts_q) begin
                  done_q       <= 1'b1;
                  status_q     <= ST_EMPTY;
                  valid_q      <= 1'b0;
                  built_cols_q <= '0;
                  built_rows_q <= '0;
                  org_x_q      <= '0;
                  org_y_q      <= '0;
                end else begin
                  ox_q    <= ox_s;
                  oy_q    <= oy_s;
                  state_q <= S_DW;
                end
              end
              MODE_READ: begin
                read_ok_q <= !bad_read;
                if (bad_read) status_q <= ST_BAD_READ;
                state_q <= S_RD;
              end
              MODE_NEW: begin
                done_q     <= 1'b1;
                has_pts_q  <= 1'b0;
                band_cnt_q <= '0;
                min_x_q    <= POS24;
                min_y_q    <= POS24;
                max_x_q    <= NEG24;
                max_y_q    <= NEG24;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (read_ok_q) cell_q <= occ_rd_q ? occ_code_q : free_code_q;
        end
        S_DW: begin
          if (div_done) begin
            w_q     <= div_quo;
            state_q <= S_DH;
          end
        end
        S_DH: begin
          if (div_done) begin
            h_q     <= div_quo;
            state_q <= S_DD;
          end
        end
        S_DD: begin
          if (div_done) begin
            if (w_q == '0 || h_q == '0 || w_q > DIV_NW'(MAX_GRID_COLS) ||
                h_q > DIV_NW'(MAX_GRID_ROWS)) begin
              done_q       <= 1'b1;
              status_q     <= ST_TOO_LARGE;
              valid_q      <= 1'b0;
              built_cols_q <= '0;
              built_rows_q <= '0;
              org_x_q      <= '0;
              org_y_q      <= '0;
              state_q      <= S_IDLE;
            end else begin
              d_q     <= d_cap;
              clr_q   <= '0;
              state_q <= S_CLR;
            end
          end
        end
        S_CLR: begin
          d2_q  <= (2*DW)'(d_q) * (2*DW)'(d_q);
          clr_q <= clr_q + 1'b1;
          if (clr_q == MAP_AW'(MAP_DEPTH - 1)) begin
            i_q     <= '0;
            state_q <= S_PRD;
          end
        end
        S_PRD: begin
          if (i_q == band_cnt_q) begin
            cx_q    <= '0;
            cy_q    <= '0;
            state_q <= S_SRD;
          end else begin
            state_q <= S_PX;
          end
        end
        S_PX: begin
          if (div_done) begin
            gx_q    <= div_quo;
            state_q <= S_PY;
          end
        end
        S_PY: begin
          if (div_done) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_PRD;
          end
        end
        S_SRD: state_q <= S_SCHK;
        S_SCHK: begin
          if (seed_rd_q) begin
            y_q     <= ylo;
            yhi_q   <= yhi;
            state_q <= S_DY;
          end else if (last_col && last_row) begin
            state_q <= S_FIN;
          end else begin
            cx_q    <= nx_cx;
            cy_q    <= nx_cy;
            state_q <= S_SRD;
          end
        end
        S_DY: begin
          dy2_q   <= dy2;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (sq_done) begin
            hw_q    <= sq_root;
            state_q <= S_XR;
          end
        end
        S_XR: begin
          x_q     <= xlo;
          xhi_q   <= xhi;
          state_q <= S_FILL;
        end
        S_FILL: begin
          if (x_q != xhi_q) begin
            x_q <= x_q + 1'b1;
          end else if (y_q != yhi_q) begin
            y_q     <= y_q + 1'b1;
            state_q <= S_DY;
          end else if (last_col && last_row) begin
            state_q <= S_FIN;
          end else begin
            cx_q    <= nx_cx;
            cy_q    <= nx_cy;
            state_q <= S_SRD;
          end
        end
        S_FIN: begin
          done_q       <= 1'b1;
          status_q     <= ST_OK;
          valid_q      <= 1'b1;
          built_cols_q <= w_q[8:0];
          built_rows_q <= h_q[8:0];
          org_x_q      <= (ox_q < 25'(NEG24)) ? NEG24 : ox_q[23:0];
          org_y_q      <= (oy_q < 25'(NEG24)) ? NEG24 : oy_q[23:0];
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = '{cell_value:  cell_q,
                    grid_cols:   built_cols_q,
                    grid_rows:   built_rows_q,
                    origin_x_mm: org_x_q,
                    origin_y_mm: org_y_q,
                    status:      status_q};

  `OCG_ASSERT(a_accept_answered, (start && !busy) |=> (done_o || busy), "accepted beat lost")
  `OCG_ASSERT(a_busy_ends_done, $fell(busy) |-> done_o, "command ended without result")
  `OCG_NEVER(a_band_bound, band_cnt_q > BCW'(MAX_BAND_POINTS), "point store overrun")
  `OCG_ASSERT(a_valid_size, valid_q |-> (built_cols_q != '0 && built_rows_q != '0), "empty grid valid")

endmodule
